### sv/csvft_pkg.sv
// csvft_pkg: shared types and constants for the CSV field tokenizer.
// Used by csvft_core, csvft_outq and csv_field_tokenizer_top. No dependencies.
package csvft_pkg;

    localparam logic [7:0] CHAR_CR = 8'd13;
    localparam logic [7:0] CHAR_LF = 8'd10;

    localparam logic [7:0] SEP_RESET = 8'd44;
    localparam logic [7:0] QUOTE_RESET = 8'd34;
    localparam logic [7:0] ESC_RESET = 8'd34;

    typedef enum logic [1:0] {
        REG_SEP   = 2'd0,
        REG_QUOTE = 2'd1,
        REG_ESC   = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_END  = 2'd1,
        KIND_EOD  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0] sep;
        logic [7:0] quote;
        logic [7:0] esc;
    } cfg_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] out_byte;
        logic       eol;
        logic       quoted;
    } result_t;

endpackage

### sv/csv_field_tokenizer_top.sv
// csv_field_tokenizer_top: streaming CSV field tokenizer, top level.
// Depends on csvft_pkg, csvft_core and csvft_outq.
//
// Takes one byte (or an end-of-input beat, s_tlast high) per cycle and splits
// the text into CSV fields: each field byte comes out as a beat of kind 0,
// each field end as a beat of kind 1 with m_tlast marking line or input end
// and m_tuser[2] marking a field that held a quoted section; an end of input
// with no bytes in the pending field gives kind 2. A beat may produce no result
// (quotes, escapes, the LF of a CR LF pair). Throughput is one beat per cycle
// while the two-entry result queue has room; the input register feeds it.
// The user must write separator, quote and escape bytes through the cfg port
// (index 0, 1, 2) only while idle; the block itself does not enforce it.
module csv_field_tokenizer_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [1:0] cfg_addr,
    input  logic [7:0] cfg_wdata,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // end_of_input
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [2:0] m_tuser,   // [1:0] kind, [2] field_quoted
    output logic       m_tlast    // end_of_line
);
    import csvft_pkg::*;

    cfg_t    cfg_reg;
    logic    q_full;
    logic    res_valid;
    result_t res;
    result_t out_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sep   <= SEP_RESET;
            cfg_reg.quote <= QUOTE_RESET;
            cfg_reg.esc   <= ESC_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_SEP:   cfg_reg.sep   <= cfg_wdata;
                REG_QUOTE: cfg_reg.quote <= cfg_wdata;
                REG_ESC:   cfg_reg.esc   <= cfg_wdata;
                default:   ;
            endcase
        end
    end

    csvft_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .in_eoi    (s_tlast),
        .q_full    (q_full),
        .res_valid (res_valid),
        .res       (res)
    );

    csvft_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (res_valid),
        .wr_data  (res),
        .full     (q_full),
        .rd_valid (m_tvalid),
        .rd_ready (m_tready),
        .rd_data  (out_res)
    );

    assign m_tdata = out_res.out_byte;
    assign m_tuser = {out_res.quoted, out_res.kind};
    assign m_tlast = out_res.eol;

endmodule

### sv/csvft_core.sv
// csvft_core: input register, tokenizer state and per-byte decode logic.
// Depends on csvft_pkg. Hands results to the output queue.
module csvft_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  csvft_pkg::cfg_t   cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    input  logic              in_eoi,
    input  logic              q_full,
    output logic              res_valid,
    output csvft_pkg::result_t res
);
    import csvft_pkg::*;

    logic       item_vld_reg;
    logic [7:0] item_byte_reg;
    logic       item_eoi_reg;

    logic inq_reg, inq_next;
    logic seen_reg, seen_next;
    logic qp_reg, qp_next;
    logic ep_reg, ep_next;
    logic cr_reg, cr_next;
    logic fhb_reg, fhb_next;

    logic advance;
    logic res_vld;
    logic do_out, emit_byte, emit_end, end_eol;
    logic [7:0] b;

    assign advance  = item_vld_reg && !q_full;
    assign in_ready = !item_vld_reg || advance;
    assign b        = item_byte_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_vld_reg <= 1'b0;
        end else if (in_ready) begin
            item_vld_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            item_byte_reg <= in_byte;
            item_eoi_reg  <= in_eoi;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inq_reg  <= 1'b0;
            seen_reg <= 1'b0;
            qp_reg   <= 1'b0;
            ep_reg   <= 1'b0;
            cr_reg   <= 1'b0;
            fhb_reg  <= 1'b0;
        end else if (advance) begin
            inq_reg  <= inq_next;
            seen_reg <= seen_next;
            qp_reg   <= qp_next;
            ep_reg   <= ep_next;
            cr_reg   <= cr_next;
            fhb_reg  <= fhb_next;
        end
    end

    always_comb begin
        inq_next  = inq_reg;
        seen_next = seen_reg;
        qp_next   = qp_reg;
        ep_next   = ep_reg;
        cr_next   = cr_reg;
        fhb_next  = fhb_reg;
        res_vld   = 1'b0;
        res       = '{kind: KIND_BYTE, out_byte: 8'd0, eol: 1'b0, quoted: 1'b0};
        do_out    = 1'b0;
        emit_byte = 1'b0;
        emit_end  = 1'b0;
        end_eol   = 1'b0;
        if (item_eoi_reg) begin
            inq_next  = 1'b0;
            seen_next = 1'b0;
            qp_next   = 1'b0;
            ep_next   = 1'b0;
            cr_next   = 1'b0;
            fhb_next  = 1'b0;
            res_vld   = 1'b1;
            if (fhb_reg) begin
                res.kind   = KIND_END;
                res.eol    = 1'b1;
                res.quoted = seen_reg;
            end else begin
                res.kind = KIND_EOD;
            end
        end else if (!(cr_reg && b == CHAR_LF)) begin
            cr_next = 1'b0;
            if (qp_reg) begin
                qp_next = 1'b0;
                if (b == cfg.quote) begin
                    emit_byte = 1'b1;
                end else begin
                    inq_next = 1'b0;
                    do_out   = 1'b1;
                end
            end else if (ep_reg) begin
                ep_next   = 1'b0;
                emit_byte = 1'b1;
            end else if (!inq_reg) begin
                do_out = 1'b1;
            end else if (cfg.esc == cfg.quote) begin
                if (b == cfg.quote) begin
                    qp_next = 1'b1;
                end else begin
                    emit_byte = 1'b1;
                end
            end else if (b == cfg.quote) begin
                inq_next = 1'b0;
            end else if (b == cfg.esc) begin
                ep_next = 1'b1;
            end else begin
                emit_byte = 1'b1;
            end

            if (do_out) begin
                if (b == cfg.quote) begin
                    inq_next  = 1'b1;
                    seen_next = 1'b1;
                end else if (b == cfg.sep) begin
                    emit_end = 1'b1;
                end else if (b == CHAR_CR) begin
                    cr_next  = 1'b1;
                    emit_end = 1'b1;
                    end_eol  = 1'b1;
                end else if (b == CHAR_LF) begin
                    emit_end = 1'b1;
                    end_eol  = 1'b1;
                end else begin
                    emit_byte = 1'b1;
                end
            end

            if (emit_byte) begin
                res_vld      = 1'b1;
                res.kind     = KIND_BYTE;
                res.out_byte = b;
                fhb_next     = 1'b1;
            end else if (emit_end) begin
                res_vld    = 1'b1;
                res.kind   = KIND_END;
                res.eol    = end_eol;
                res.quoted = seen_reg;
                seen_next  = 1'b0;
                fhb_next   = 1'b0;
            end
        end else begin
            // LF right after CR: dropped
            cr_next = 1'b0;
        end
    end

    assign res_valid = advance && res_vld;

endmodule

### sv/csvft_outq.sv
// csvft_outq: two-entry result queue that registers the output beat and
// decouples m_tready from the input side. Depends on csvft_pkg.
module csvft_outq (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_en,
    input  csvft_pkg::result_t wr_data,
    output logic               full,
    output logic               rd_valid,
    input  logic               rd_ready,
    output csvft_pkg::result_t rd_data
);
    import csvft_pkg::*;

    result_t    ent_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       rd_en;

    assign full     = (count_reg == 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_en    = rd_valid && rd_ready;
    assign rd_data  = ent_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (wr_en && !rd_en) begin
            count_next = count_reg + 2'd1;
        end else if (!wr_en && rd_en) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (wr_en) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (rd_en) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
        if (wr_en) begin
            ent_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### dv/csvft_checker.sv
// csvft_checker: predicts the CSV field tokenizer's result beats from the
// input and config traffic and compares them with the m_ channel.
// Depends on csvft_pkg.
`timescale 1ns / 1ps

module csvft_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [1:0] cfg_addr,
    input  logic [7:0] cfg_wdata,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic [2:0] m_tuser,
    input  logic       m_tlast,
    output int         fail_count,
    output int         pending_results
);
    import csvft_pkg::*;

    logic [7:0] sep_c;
    logic [7:0] quote_c;
    logic [7:0] esc_c;

    logic in_quotes;
    logic quoted_seen;
    logic quote_hold;
    logic esc_hold;
    logic cr_hold;
    logic has_bytes;

    result_t tokens_due[$];

    function automatic void clear_tok();
        in_quotes   = 1'b0;
        quoted_seen = 1'b0;
        quote_hold  = 1'b0;
        esc_hold    = 1'b0;
        cr_hold     = 1'b0;
        has_bytes   = 1'b0;
    endfunction

    function automatic result_t field_byte(input logic [7:0] b);
        result_t r;
        r = '0;
        r.kind = KIND_BYTE;
        r.out_byte = b;
        has_bytes = 1'b1;
        return r;
    endfunction

    function automatic result_t field_end(input logic eol);
        result_t r;
        r = '0;
        r.kind = KIND_END;
        r.eol = eol;
        r.quoted = quoted_seen;
        quoted_seen = 1'b0;
        has_bytes = 1'b0;
        return r;
    endfunction

    // byte seen outside quotes: quote, then separator, then CR/LF
    function automatic bit take_plain(input logic [7:0] b, output result_t r);
        r = '0;
        if (b == quote_c) begin
            in_quotes = 1'b1;
            quoted_seen = 1'b1;
            return 1'b0;
        end
        if (b == sep_c) begin
            r = field_end(1'b0);
            return 1'b1;
        end
        if (b == CHAR_CR) begin
            cr_hold = 1'b1;
            r = field_end(1'b1);
            return 1'b1;
        end
        if (b == CHAR_LF) begin
            r = field_end(1'b1);
            return 1'b1;
        end
        r = field_byte(b);
        return 1'b1;
    endfunction

    function automatic bit tokenize(input logic [7:0] b, input logic eoi, output result_t r);
        r = '0;
        if (eoi) begin
            r.kind = has_bytes ? KIND_END : KIND_EOD;
            r.eol = has_bytes;
            r.quoted = has_bytes & quoted_seen;
            clear_tok();
            return 1'b1;
        end
        if (cr_hold) begin
            cr_hold = 1'b0;
            if (b == CHAR_LF) return 1'b0;
        end
        if (quote_hold) begin
            quote_hold = 1'b0;
            if (b == quote_c) begin
                r = field_byte(b);
                return 1'b1;
            end
            in_quotes = 1'b0;
            return take_plain(b, r);
        end
        if (esc_hold) begin
            esc_hold = 1'b0;
            r = field_byte(b);
            return 1'b1;
        end
        if (!in_quotes) return take_plain(b, r);
        if (esc_c == quote_c) begin
            if (b == quote_c) begin
                quote_hold = 1'b1;
                return 1'b0;
            end
            r = field_byte(b);
            return 1'b1;
        end
        if (b == quote_c) begin
            in_quotes = 1'b0;
            return 1'b0;
        end
        if (b == esc_c) begin
            esc_hold = 1'b1;
            return 1'b0;
        end
        r = field_byte(b);
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns  csvft mismatch: %s got %0d want %0d", $time, what, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        result_t want;
        result_t got;
        if (!aresetn) begin
            sep_c = SEP_RESET;
            quote_c = QUOTE_RESET;
            esc_c = ESC_RESET;
            clear_tok();
            tokens_due.delete();
            fail_count = 0;
        end else begin
            if (cfg_we) begin
                case (reg_idx_t'(cfg_addr))
                    REG_SEP:   sep_c = cfg_wdata;
                    REG_QUOTE: quote_c = cfg_wdata;
                    REG_ESC:   esc_c = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                if (tokenize(s_tdata, s_tlast, want)) tokens_due.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got.kind = kind_t'(m_tuser[1:0]);
                got.out_byte = m_tdata;
                got.eol = m_tlast;
                got.quoted = m_tuser[2];
                if (tokens_due.size() == 0) begin
                    report_mismatch("beat with nothing due, kind", got.kind, -1);
                end else begin
                    want = tokens_due.pop_front();
                    if (got.kind != want.kind) report_mismatch("kind", got.kind, want.kind);
                    if (got.out_byte != want.out_byte)
                        report_mismatch("out_byte", got.out_byte, want.out_byte);
                    if (got.eol != want.eol) report_mismatch("end_of_line", got.eol, want.eol);
                    if (got.quoted != want.quoted)
                        report_mismatch("field_quoted", got.quoted, want.quoted);
                end
            end
        end
        pending_results <= tokens_due.size();
    end

endmodule

### dv/csv_field_tokenizer_top_test.sv
// csv_field_tokenizer_top_test: drives CSV text and config phases into
// csv_field_tokenizer_top with random gaps and stalls; csvft_checker judges.
// Depends on csvft_pkg, csv_field_tokenizer_top and csvft_checker.
`timescale 1ns / 1ps

module csv_field_tokenizer_top_test;
    import csvft_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE = 4;
    localparam int PHASE_ITEMS = 110;
    localparam int LONG_HOLD = 300;

    typedef struct packed {
        logic [7:0] data;
        logic       eoi;
    } text_beat_t;

    logic       aclk;
    logic       aresetn;
    logic       cfg_we;
    logic [1:0] cfg_addr;
    logic [7:0] cfg_wdata;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic [2:0] m_tuser;
    logic       m_tlast;
    int         fail_count;
    int         pending_results;

    logic [7:0] sep_b;
    logic [7:0] quote_b;
    logic [7:0] esc_b;
    int         hold_reqs;
    int         stall_cycles;
    text_beat_t script_q[$];

    csv_field_tokenizer_top i_dut (.*);
    csvft_checker i_check (.*);

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("csv_field_tokenizer_top_test: done, errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // result side: random stalls, bursts with none, one long hold-off on request
    initial begin
        int unsigned gap;
        int unsigned taken;
        int          holds_done;
        m_tready <= 1'b0;
        taken = 0;
        holds_done = 0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (hold_reqs != holds_done) begin
                gap = LONG_HOLD;
                holds_done++;
            end else if (taken % 50 < 12) begin
                gap = 0;
            end else begin
                gap = $urandom_range(0, 4);
            end
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            taken++;
        end
    end

    function automatic void add_beat(input logic [7:0] b);
        text_beat_t t;
        t.data = b;
        t.eoi = 1'b0;
        script_q.push_back(t);
    endfunction

    function automatic void add_end();
        text_beat_t t;
        t.data = 8'($urandom_range(0, 255));
        t.eoi = 1'b1;
        script_q.push_back(t);
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == sep_b || b == quote_b || b == CHAR_CR || b == CHAR_LF);
        return b;
    endfunction

    // in doubled-quote mode esc_b equals quote_b, so the prefix doubles the quote
    function automatic void add_quoted_byte();
        logic [7:0] b;
        case ($urandom_range(0, 9))
            0: b = sep_b;
            1: b = CHAR_CR;
            2: b = CHAR_LF;
            3: b = quote_b;
            default: b = 8'($urandom_range(0, 255));
        endcase
        if (b == quote_b || b == esc_b) add_beat(esc_b);
        add_beat(b);
    endfunction

    function automatic void add_field();
        int unsigned n;
        if ($urandom_range(0, 1) == 0) begin
            n = $urandom_range(0, 5);
            repeat (n) add_beat(plain_byte());
        end else begin
            add_beat(quote_b);
            n = $urandom_range(0, 6);
            repeat (n) add_quoted_byte();
            add_beat(quote_b);
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
            repeat (n) add_beat(plain_byte());
        end
    endfunction

    function automatic void add_record();
        int unsigned nf;
        nf = $urandom_range(1, 4);
        for (int i = 0; i < nf; i++) begin
            if (i != 0) add_beat(sep_b);
            add_field();
            if ($urandom_range(0, 15) == 0) add_beat(8'($urandom_range(0, 255)));
        end
        case ($urandom_range(0, 5))
            0: add_beat(CHAR_CR);
            1, 2: begin
                add_beat(CHAR_CR);
                add_beat(CHAR_LF);
            end
            3: add_end();
            default: add_beat(CHAR_LF);
        endcase
    endfunction

    function automatic void add_random(input int n);
        int unsigned k;
        while (script_q.size() < n) begin
            if ($urandom_range(0, 5) == 0) begin
                k = $urandom_range(1, 3);
                repeat (k) add_beat(8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 29) == 0) add_end();
            add_record();
        end
    endfunction

    task automatic wait_idle(input int extra);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [7:0] v);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
    endtask

    task automatic apply_config(input logic [7:0] sep, input logic [7:0] quote,
                                input logic [7:0] esc);
        wait_idle(SETTLE);
        write_reg(REG_SEP, sep);
        write_reg(REG_QUOTE, quote);
        write_reg(REG_ESC, esc);
        cfg_we <= 1'b0;
        sep_b = sep;
        quote_b = quote;
        esc_b = esc;
    endtask

    task automatic send_beat(input text_beat_t t, input bit no_gap);
        int unsigned gap;
        gap = no_gap ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= t.data;
        s_tlast <= t.eoi;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic play_script(input int pause_at);
        text_beat_t t;
        int k;
        k = 0;
        while (script_q.size() != 0) begin
            t = script_q.pop_front();
            if (k == pause_at) wait_idle(0);
            send_beat(t, (k % 64) < 16);
            k++;
        end
    endtask

    initial begin
        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_addr <= REG_SEP;
        cfg_wdata <= 8'd0;
        s_tvalid <= 1'b0;
        s_tdata <= 8'd0;
        s_tlast <= 1'b0;
        hold_reqs = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // default chars: plain, doubled quote, quote closed by CR, CR LF,
        // empty quoted field at end of input, byte extremes, CR then a byte,
        // quote still pending at end of input, end of input with no field
        apply_config(SEP_RESET, QUOTE_RESET, ESC_RESET);
        add_beat("a");
        add_beat(sep_b);
        add_beat(quote_b);
        add_beat("b");
        add_beat(quote_b);
        add_beat(quote_b);
        add_beat("c");
        add_beat(quote_b);
        add_beat(CHAR_CR);
        add_beat(CHAR_LF);
        add_beat(quote_b);
        add_beat(quote_b);
        add_end();
        add_beat(8'hFF);
        add_beat(CHAR_CR);
        add_beat(8'h00);
        add_beat(quote_b);
        add_beat("x");
        add_beat(quote_b);
        add_end();
        add_end();
        play_script(-1);

        hold_reqs++;
        add_random(PHASE_ITEMS);
        play_script(-1);

        // escape mode: escaped quote, escape still pending at end of input
        apply_config(",", "\"", "\\");
        add_beat(quote_b);
        add_beat(esc_b);
        add_beat(quote_b);
        add_beat("q");
        add_beat(esc_b);
        add_end();
        add_random(PHASE_ITEMS);
        play_script(60);

        apply_config(8'h00, 8'hFF, 8'hFF);
        add_random(PHASE_ITEMS);
        play_script(-1);

        apply_config(8'hFF, 8'h00, 8'h00);
        add_random(PHASE_ITEMS);
        play_script(-1);

        apply_config(8'h00, 8'hFF, 8'h00);
        add_random(PHASE_ITEMS);
        play_script(-1);

        apply_config(8'h09, "'", "'");
        add_random(PHASE_ITEMS);
        play_script(-1);

        repeat (2) begin
            apply_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)));
            add_random(PHASE_ITEMS);
            play_script(-1);
        end

        wait_idle(2 * SETTLE);
        if (fail_count == 0) begin
            $display("csv_field_tokenizer_top_test: done, clean");
        end else begin
            $display("csv_field_tokenizer_top_test: done, errors");
        end
        $finish;
    end

endmodule
